// ===== rtl/energy_gate_audio_slicer_assert.svh =====
// Assertion macros for the energy gated audio slicer
`ifndef ENERGY_GATE_AUDIO_SLICER_ASSERT_SVH
`define ENERGY_GATE_AUDIO_SLICER_ASSERT_SVH
`ifndef SYNTHESIS
`define EGAS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("egas assertion failed");
`define EGAS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("egas assertion failed");
`else
`define EGAS_ASSERT(lbl, clk, rstn, prop)
`define EGAS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/egas_pkg.sv =====
// Types and constants shared by the energy gated audio slicer
`timescale 1ns / 1ps
package egas_pkg;

  localparam int unsigned WLEN_BITS   = 13;
  localparam int unsigned HOP_BITS    = 16;
  localparam int unsigned MINS_BITS   = 32;
  localparam int unsigned THR_BITS    = 48;
  localparam int unsigned CUT_BITS    = 32;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 48;

  localparam logic [WLEN_BITS-1:0] WLEN_RESET = 13'd1024;
  localparam logic [HOP_BITS-1:0]  HOP_RESET  = 16'd512;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_LENGTH    = 2'd0,
    REG_HOP_SIZE         = 2'd1,
    REG_MIN_SAMPLES      = 2'd2,
    REG_ENERGY_THRESHOLD = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                fin;
    logic [CUT_BITS-1:0] pos;
  } res_t;

endpackage

// ===== rtl/energy_gate_audio_slicer.sv =====
// Energy gated audio slicer: windowed energy tracking and cut generation
`timescale 1ns / 1ps
// Usage:
//   Samples enter on the s_t* stream (sample in s_tdata, end of stream on
//   s_tlast). Cut positions leave on the m_t* stream (position in m_tdata,
//   m_tlast marks the closing cut that carries the total sample count).
//   Registers are written on the cfg_* channel, which is always ready; write
//   only while the block is idle. Writing window_length or hop_size restarts
//   the stream state.
// Timing:
//   One sample per cycle sustained while s_tready is high. A sample passes
//   an input stage (which also reads the oldest sample from the history
//   RAM), a squaring stage and the energy/decision stage, which puts its
//   results into the result buffer that feeds m_t*. The history RAM gives
//   one read and one write per cycle, which sets the rate.
// Reset and stall:
//   Reset clears the stream state and loads the register defaults; the
//   history RAM is not cleared as only entries written in the current stream
//   are read. Results queue in a four-entry buffer; s_tready drops while it
//   holds three or more, so a stalled receiver stalls the input after that.
module energy_gate_audio_slicer #(
  parameter int unsigned WINDOW_MAX  = 4096,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // fields: sample [SAMPLE_BITS-1:0], zero fill above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
  input  logic                                 s_tlast,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // fields: cut_position [31:0]
  output logic [egas_pkg::CUT_BITS-1:0]        m_tdata,
  output logic                                 m_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [egas_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [egas_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

`include "energy_gate_audio_slicer_assert.svh"

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned CB  = COUNT_BITS;
  localparam int unsigned AW  = $clog2(WINDOW_MAX);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned SQW = 2 * SB - 1;
  localparam int unsigned EW  = 2 * SB - 1 + AW;
  localparam int unsigned CW  = (EW > egas_pkg::THR_BITS) ? EW : egas_pkg::THR_BITS;
  localparam int unsigned XW  = (CB > 32) ? CB : 32;
  localparam logic [CB-1:0]  COUNT_MAX = {CB{1'b1}};
  localparam logic [XW:0]    CUT_SAT   = (XW + 1)'(COUNT_MAX);
  localparam logic [PW-1:0]  WMAX_P    = PW'(WINDOW_MAX);

  // ---------------------------------------------------------------- config
  logic [egas_pkg::WLEN_BITS-1:0] wlen_q;
  logic [egas_pkg::HOP_BITS-1:0]  hop_q;
  logic [egas_pkg::MINS_BITS-1:0] mins_q;
  logic [egas_pkg::THR_BITS-1:0]  thr_q;
  logic                           cfg_clr;

  assign cfg_ready_o = 1'b1;
  assign cfg_clr = cfg_valid_i &&
                   (cfg_index_i == egas_pkg::REG_WINDOW_LENGTH ||
                    cfg_index_i == egas_pkg::REG_HOP_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= egas_pkg::WLEN_RESET;
      hop_q  <= egas_pkg::HOP_RESET;
      mins_q <= '0;
      thr_q  <= '0;
    end else if (cfg_valid_i) begin
      case (egas_pkg::cfg_reg_e'(cfg_index_i))
        egas_pkg::REG_WINDOW_LENGTH:    wlen_q <= cfg_data_i[egas_pkg::WLEN_BITS-1:0];
        egas_pkg::REG_HOP_SIZE:         hop_q  <= cfg_data_i[egas_pkg::HOP_BITS-1:0];
        egas_pkg::REG_MIN_SAMPLES:      mins_q <= cfg_data_i[egas_pkg::MINS_BITS-1:0];
        egas_pkg::REG_ENERGY_THRESHOLD: thr_q  <= cfg_data_i[egas_pkg::THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [PW-1:0]                  w_eff;
  logic [egas_pkg::HOP_BITS-1:0]  h_eff;

  always_comb begin
    if (wlen_q == '0) begin
      w_eff = PW'(1);
    end else if (32'(wlen_q) > 32'(WINDOW_MAX)) begin
      w_eff = WMAX_P;
    end else begin
      w_eff = PW'(wlen_q);
    end
    h_eff = (hop_q == '0) ? egas_pkg::HOP_BITS'(1) : hop_q;
  end

  // ---------------------------------------------------------------- flow control
  logic [egas_pkg::FIFO_AW:0] fcnt_q, fcnt_d;
  logic                       adv;
  logic                       acc;

  assign adv      = fcnt_q <= (egas_pkg::FIFO_AW + 1)'(egas_pkg::FIFO_DEPTH - 2);
  assign s_tready = adv;
  assign acc      = s_tvalid && adv;

  // ---------------------------------------------------------------- front stage
  logic [CB-1:0]                 count_q, count_d;
  logic [AW-1:0]                 wptr_q, wptr_d;
  logic [egas_pkg::HOP_BITS-1:0] hop_ph_q, hop_ph_d;
  logic                          sat, has_old;
  logic [CB-1:0]                 p_cur, cnt_after;
  logic [AW-1:0]                 raddr;
  logic [PW-1:0]                 wptr_x;
  logic [egas_pkg::HOP_BITS:0]   hop_inc;

  always_comb begin
    sat       = count_q == COUNT_MAX;
    has_old   = XW'(count_q) >= XW'(w_eff);
    p_cur     = CB'(XW'(count_q) - XW'(w_eff));
    cnt_after = sat ? count_q : count_q + CB'(1);
    wptr_x    = {1'b0, wptr_q};
    if (wptr_x >= w_eff) begin
      raddr = AW'(wptr_x - w_eff);
    end else begin
      raddr = AW'(wptr_x + WMAX_P - w_eff);
    end
    hop_inc = {1'b0, hop_ph_q} + (egas_pkg::HOP_BITS + 1)'(1);

    count_d  = count_q;
    wptr_d   = wptr_q;
    hop_ph_d = hop_ph_q;
    if (cfg_clr) begin
      count_d  = '0;
      wptr_d   = '0;
      hop_ph_d = '0;
    end else if (acc) begin
      if (s_tlast) begin
        count_d  = '0;
        wptr_d   = '0;
        hop_ph_d = '0;
      end else if (!sat) begin
        count_d = cnt_after;
        wptr_d  = (wptr_x + PW'(1) == WMAX_P) ? '0 : wptr_q + AW'(1);
        if (has_old) begin
          hop_ph_d = (hop_inc >= {1'b0, h_eff}) ? '0 : hop_inc[egas_pkg::HOP_BITS-1:0];
        end
      end
    end
  end

  // sample history; a read and a write at the same address return the old entry
  logic [SB-1:0] hist_mem [WINDOW_MAX];
  logic [SB-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (acc && !sat) begin
      hist_mem[wptr_q] <= s_tdata[SB-1:0];
    end
    if (adv) begin
      rd_q <= hist_mem[raddr];
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic          s1_vld_q;
  logic [SB-1:0] s1_smp_q;
  logic          s1_eos_q, s1_first_q, s1_upd_q, s1_old_q, s1_judge_q;
  logic [CB-1:0] s1_p_q, s1_cnt_q;

  // ---------------------------------------------------------------- stage 2
  logic           s2_vld_q;
  logic [SQW-1:0] s2_sqn_q, s2_sqo_q;
  logic           s2_eos_q, s2_first_q, s2_judge_q;
  logic [CB-1:0]  s2_p_q, s2_cnt_q;
  logic [2*SB-1:0] sq_new, sq_old;

  assign sq_new = $signed(s1_smp_q) * $signed(s1_smp_q);
  assign sq_old = $signed(rd_q) * $signed(rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wptr_q   <= '0;
      hop_ph_q <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      wptr_q   <= wptr_d;
      hop_ph_q <= hop_ph_d;
      if (cfg_clr) begin
        s1_vld_q <= 1'b0;
        s2_vld_q <= 1'b0;
      end else if (adv) begin
        s1_vld_q <= acc;
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_smp_q   <= s_tdata[SB-1:0];
      s1_eos_q   <= s_tlast;
      s1_first_q <= count_q == '0;
      s1_upd_q   <= !sat;
      s1_old_q   <= has_old && !sat;
      s1_judge_q <= has_old && !sat && hop_ph_q == '0;
      s1_p_q     <= p_cur;
      s1_cnt_q   <= cnt_after;

      s2_sqn_q   <= s1_upd_q ? sq_new[SQW-1:0] : '0;
      s2_sqo_q   <= s1_old_q ? sq_old[SQW-1:0] : '0;
      s2_eos_q   <= s1_eos_q;
      s2_first_q <= s1_first_q;
      s2_judge_q <= s1_judge_q;
      s2_p_q     <= s1_p_q;
      s2_cnt_q   <= s1_cnt_q;
    end
  end

  // ---------------------------------------------------------------- decision stage
  logic [EW-1:0] energy_q, energy_d;
  logic          last_act_q, last_act_d;
  logic          first_done_q, first_done_d;
  logic [CB-1:0] last_cut_q, last_cut_d;
  logic          act, gap_ok, cut_fire, back_go;
  logic [XW:0]   cut_sum, cut_sat;
  egas_pkg::res_t res_first, res_cut, res_eos, slot_a, slot_b;
  logic [1:0]    npush;

  always_comb begin
    back_go = adv && s2_vld_q;
    act     = CW'(energy_q) > CW'(thr_q);
    gap_ok  = (XW'(s2_p_q) - XW'(last_cut_q)) >= XW'(mins_q);
    cut_fire = s2_judge_q && first_done_q && gap_ok && (act != last_act_q);
    cut_sum = (XW + 1)'(s2_p_q) + (XW + 1)'(h_eff >> 1);
    cut_sat = (cut_sum > CUT_SAT) ? CUT_SAT : cut_sum;

    res_first = '{fin: 1'b0, pos: '0};
    res_cut   = '{fin: 1'b0, pos: egas_pkg::CUT_BITS'(cut_sat)};
    res_eos   = '{fin: 1'b1, pos: egas_pkg::CUT_BITS'(s2_cnt_q)};

    if (s2_first_q) begin
      slot_a = res_first;
    end else if (cut_fire) begin
      slot_a = res_cut;
    end else begin
      slot_a = res_eos;
    end
    slot_b = res_eos;
    npush  = 2'(s2_first_q) + 2'(cut_fire) + 2'(s2_eos_q);

    energy_d     = energy_q;
    last_act_d   = last_act_q;
    first_done_d = first_done_q;
    last_cut_d   = last_cut_q;
    if (cfg_clr) begin
      energy_d     = '0;
      last_act_d   = 1'b0;
      first_done_d = 1'b0;
      last_cut_d   = '0;
    end else if (back_go) begin
      if (s2_judge_q) begin
        if (!first_done_q) begin
          // opening window only sets the state
          last_act_d   = act;
          first_done_d = 1'b1;
        end else if (gap_ok) begin
          last_act_d = act;
          if (cut_fire) begin
            last_cut_d = s2_p_q;
          end
        end
      end
      energy_d = energy_q + EW'(s2_sqn_q) - EW'(s2_sqo_q);
      if (s2_eos_q) begin
        energy_d     = '0;
        last_act_d   = 1'b0;
        first_done_d = 1'b0;
        last_cut_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q     <= '0;
      last_act_q   <= 1'b0;
      first_done_q <= 1'b0;
      last_cut_q   <= '0;
    end else begin
      energy_q     <= energy_d;
      last_act_q   <= last_act_d;
      first_done_q <= first_done_d;
      last_cut_q   <= last_cut_d;
    end
  end

  // ---------------------------------------------------------------- result queue
  egas_pkg::res_t               fifo_q [egas_pkg::FIFO_DEPTH];
  logic [egas_pkg::FIFO_AW-1:0] fwp_q, frp_q;
  logic [1:0]                   nput;
  logic                         pop;

  assign nput     = back_go ? npush : 2'd0;
  assign m_tvalid = fcnt_q != '0;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = fifo_q[frp_q].pos;
  assign m_tlast  = fifo_q[frp_q].fin;
  assign fcnt_d   = fcnt_q + (egas_pkg::FIFO_AW + 1)'(nput) -
                    (egas_pkg::FIFO_AW + 1)'(pop);

  always_ff @(posedge clk_i) begin
    if (nput != 2'd0) begin
      fifo_q[fwp_q] <= slot_a;
    end
    if (nput == 2'd2) begin
      fifo_q[fwp_q + egas_pkg::FIFO_AW'(1)] <= slot_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwp_q  <= '0;
      frp_q  <= '0;
      fcnt_q <= '0;
    end else begin
      fwp_q  <= fwp_q + egas_pkg::FIFO_AW'(nput);
      frp_q  <= frp_q + egas_pkg::FIFO_AW'(pop);
      fcnt_q <= fcnt_d;
    end
  end

  // ---------------------------------------------------------------- assertions
  `EGAS_ASSERT(a_fifo_bound, clk_i, rst_ni,
    fcnt_q <= (egas_pkg::FIFO_AW + 1)'(egas_pkg::FIFO_DEPTH))
  `EGAS_ASSERT(a_eos_clears, clk_i, rst_ni,
    back_go && s2_eos_q && !cfg_clr |=> energy_q == '0 && !first_done_q)
  `EGAS_ASSERT(a_cfg_restart, clk_i, rst_ni,
    cfg_clr |=> count_q == '0 && wptr_q == '0 && hop_ph_q == '0)
  `EGAS_ASSERT(a_sat_holds, clk_i, rst_ni,
    acc && sat && !s_tlast && !cfg_clr |=> count_q == COUNT_MAX)

endmodule
